/* rtl/rmmst_pkg.sv */
// Package for the range min/max segment tree: sizes, request and status codes,
// node record and the shared node-merge function. No dependencies.
`timescale 1ns / 1ps

package rmmst_pkg;

    localparam int LEAVES     = 1024;
    localparam int NODE_AW    = $clog2(2 * LEAVES);
    localparam int POS_W      = NODE_AW + 1;
    localparam int IDX_W      = 11;
    localparam int VALUE_W    = 32;
    localparam int NODE_COUNT = 2 * LEAVES;

    // Request kinds and result status codes
    localparam logic OP_UPDATE   = 1'b0;
    localparam logic OP_QUERY    = 1'b1;
    localparam logic STAT_OK     = 1'b0;
    localparam logic STAT_BADIDX = 1'b1;

    typedef struct packed {
        logic               valid;
        logic signed [VALUE_W-1:0] max_v;
        logic signed [VALUE_W-1:0] min_v;
    } node_t;

    // Merge two nodes; an empty node is all zero and drops out.
    function automatic node_t node_merge(input node_t a, input node_t b);
        node_t r;
        r = '0;
        if (a.valid && b.valid) begin
            r.valid = 1'b1;
            r.max_v = (a.max_v > b.max_v) ? a.max_v : b.max_v;
            r.min_v = (a.min_v < b.min_v) ? a.min_v : b.min_v;
        end else if (a.valid) begin
            r = a;
        end else if (b.valid) begin
            r = b;
        end
        return r;
    endfunction

endpackage

/* rtl/rmmst_store.sv */
// Node store of the segment tree: one write port, one registered read port.
// Depends on rmmst_pkg.
`timescale 1ns / 1ps

module rmmst_store
    import rmmst_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [NODE_AW-1:0] waddr,
    input  node_t              wdata,
    input  logic [NODE_AW-1:0] raddr,
    output node_t              rdata
);

    node_t mem [NODE_COUNT];
    node_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/range_min_max_segment_tree.sv */
// Top level of the range min/max segment tree: handshakes, sequencer and the
// shared merge unit. Depends on rmmst_pkg and rmmst_store.
`timescale 1ns / 1ps

// Segment tree over 1024 signed 32-bit slots held in one 2048-entry node RAM.
// After reset, and after every write of the slot count, the RAM is swept clear
// one node a cycle and no request is taken meanwhile. An update walks up the
// tree, reading the sibling and then merging and writing the parent at each
// level; a query walks both range ends up the tree, merging edge nodes. A bad
// index is answered in the cycle after acceptance. One request is in flight
// at a time; the pace is set by the single RAM read port and the merge unit.
module range_min_max_segment_tree
    import rmmst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [IDX_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      req_type,
    input  logic [IDX_W-1:0]          left_index,
    input  logic [IDX_W-1:0]          right_index,
    input  logic signed [VALUE_W-1:0] new_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VALUE_W-1:0] range_max,
    output logic signed [VALUE_W-1:0] range_min,
    output logic                      any_set,
    output logic                      status
);

    typedef enum logic [7:0] {
        ST_CLR   = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_U_RD  = 8'b0000_0100,
        ST_U_WR  = 8'b0000_1000,
        ST_Q_LO  = 8'b0001_0000,
        ST_Q_LOW = 8'b0010_0000,
        ST_Q_HI  = 8'b0100_0000,
        ST_Q_HIW = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      n_reg, n_next;
    logic [NODE_AW-1:0]    cnt_reg, cnt_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [POS_W-1:0]      hi_reg, hi_next;
    node_t                 acc_reg, acc_next;
    logic                  out_valid_reg, out_valid_next;
    node_t                 res_reg, res_next;
    logic                  status_reg, status_next;

    logic                  we;
    logic [NODE_AW-1:0]    waddr, raddr;
    node_t                 wdata, rdata, merged, leaf;
    logic [IDX_W-1:0]      n_eff;
    logic                  bad;
    logic [POS_W-1:0]      hi_dec;

    rmmst_store u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign merged = node_merge(acc_reg, rdata);
    assign n_eff  = (n_reg > IDX_W'(LEAVES)) ? IDX_W'(LEAVES) : n_reg;
    assign hi_dec = hi_reg - POS_W'(1);

    always_comb
    begin
        bad = (left_index == '0) || (left_index > n_eff);
        if (req_type == OP_QUERY)
        begin
            bad = bad || (right_index == '0) || (right_index > n_eff)
                  || (left_index > right_index);
        end
        leaf       = '0;
        leaf.valid = 1'b1;
        leaf.max_v = new_value;
        leaf.min_v = new_value;
    end

    // a config beat wins over a request beat offered in the same cycle
    assign cfg_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg && !cfg_valid;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        hi_next        = hi_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        we             = 1'b0;
        waddr          = pos_reg[NODE_AW-1:0];
        wdata          = '0;
        raddr          = pos_reg[NODE_AW-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLR:
            begin
                we       = 1'b1;
                waddr    = cnt_reg;
                cnt_next = cnt_reg + NODE_AW'(1);
                if (cnt_reg == NODE_AW'(NODE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cfg_valid && cfg_ready)
                begin
                    n_next     = cfg_data;
                    cnt_next   = '0;
                    state_next = ST_CLR;
                end else if (in_valid && in_ready)
                begin
                    pos_next = POS_W'(LEAVES) + POS_W'(left_index) - POS_W'(1);
                    hi_next  = POS_W'(LEAVES) + POS_W'(right_index);
                    acc_next = '0;
                    if (bad)
                    begin
                        res_next       = '0;
                        status_next    = STAT_BADIDX;
                        out_valid_next = 1'b1;
                    end else if (req_type == OP_UPDATE)
                    begin
                        we         = 1'b1;
                        waddr      = pos_next[NODE_AW-1:0];
                        wdata      = leaf;
                        acc_next   = leaf;
                        state_next = ST_U_RD;
                    end else
                    begin
                        state_next = ST_Q_LO;
                    end
                end
            end
            ST_U_RD:
            begin
                raddr = pos_reg[NODE_AW-1:0] ^ NODE_AW'(1);
                if (pos_reg == POS_W'(1))
                begin
                    res_next       = '0;
                    status_next    = STAT_OK;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end else
                begin
                    state_next = ST_U_WR;
                end
            end
            ST_U_WR:
            begin
                pos_next   = pos_reg >> 1;
                acc_next   = merged;
                we         = 1'b1;
                waddr      = pos_next[NODE_AW-1:0];
                wdata      = merged;
                state_next = ST_U_RD;
            end
            ST_Q_LO:
            begin
                if (pos_reg >= hi_reg)
                begin
                    res_next       = acc_reg;
                    status_next    = STAT_OK;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end else if (pos_reg[0])
                begin
                    raddr      = pos_reg[NODE_AW-1:0];
                    pos_next   = pos_reg + POS_W'(1);
                    state_next = ST_Q_LOW;
                end else
                begin
                    state_next = ST_Q_HI;
                end
            end
            ST_Q_LOW:
            begin
                acc_next   = merged;
                state_next = ST_Q_HI;
            end
            ST_Q_HI:
            begin
                if (hi_reg[0])
                begin
                    raddr      = hi_dec[NODE_AW-1:0];
                    hi_next    = hi_dec;
                    state_next = ST_Q_HIW;
                end else
                begin
                    pos_next   = pos_reg >> 1;
                    hi_next    = hi_reg >> 1;
                    state_next = ST_Q_LO;
                end
            end
            ST_Q_HIW:
            begin
                acc_next   = merged;
                pos_next   = pos_reg >> 1;
                hi_next    = hi_reg >> 1;
                state_next = ST_Q_LO;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            n_reg         <= IDX_W'(LEAVES);
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        hi_reg     <= hi_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign range_max = res_reg.max_v;
    assign range_min = res_reg.min_v;
    assign any_set   = res_reg.valid;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLR) |-> !in_ready && !cfg_ready)
        else $error("request taken during clearing sweep");

    a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (range_max == '0) && (range_min == '0) && !any_set)
        else $error("error result carries data");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !any_set) |-> (range_max == '0) && (range_min == '0))
        else $error("empty result not zero");

    a_busy_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (req_type == OP_QUERY) && !bad) |=> (state_reg == ST_Q_LO))
        else $error("query did not start walk");
`endif

endmodule

/* tb/range_min_max_segment_tree_tb.sv */
// Self-checking bench for range_min_max_segment_tree: directed table, then random
// updates/queries predicted by a local slot array. Depends on rmmst_pkg and the RTL.
`timescale 1ns / 1ps

module range_min_max_segment_tree_tb
    import rmmst_pkg::*;
();

    typedef struct {
        bit                  kind;
        logic [IDX_W-1:0]    lidx;
        logic [IDX_W-1:0]    ridx;
        logic signed [31:0]  val;
        bit                  typed;   // expected row typed in below
        logic signed [31:0]  emax;
        logic signed [31:0]  emin;
        bit                  eany;
        bit                  est;
    } req_row_t;

    typedef struct {
        logic signed [31:0] mx;
        logic signed [31:0] mn;
        bit                 any;
        bit                 st;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic req_type = 1'b0;
    logic [IDX_W-1:0] left_index = '0;
    logic [IDX_W-1:0] right_index = '0;
    logic signed [VALUE_W-1:0] new_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [VALUE_W-1:0] range_max, range_min;
    logic any_set, status;

    logic signed [31:0] slot_val [1:LEAVES];
    bit                 slot_set [1:LEAVES];
    int unsigned        slots_live = LEAVES;
    answer_t            pending_answers [$];
    int                 errors = 0;
    bit                 hold_off = 1'b0;

    range_min_max_segment_tree dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50ms;
        $display("range_min_max_segment_tree test failed");
        $finish;
    end

    function automatic void clear_slots();
        for (int i = 1; i <= LEAVES; i++)
        begin
            slot_set[i] = 1'b0;
            slot_val[i] = '0;
        end
    endfunction

    function automatic answer_t predict_answer(bit kind, int unsigned a, int unsigned b,
                                               logic signed [31:0] v);
        answer_t r;
        int unsigned n;
        r = '{0, 0, 0, STAT_OK};
        n = (slots_live > LEAVES) ? LEAVES : slots_live;
        if (kind == OP_UPDATE)
        begin
            if (a < 1 || a > n)
                r.st = STAT_BADIDX;
            else
            begin
                slot_val[a] = v;
                slot_set[a] = 1'b1;
            end
            return r;
        end
        if (a < 1 || b < 1 || a > n || b > n || a > b)
        begin
            r.st = STAT_BADIDX;
            return r;
        end
        for (int i = a; i <= b; i++)
            if (slot_set[i])
            begin
                if (!r.any)
                begin
                    r.mx = slot_val[i];
                    r.mn = slot_val[i];
                    r.any = 1'b1;
                end
                else
                begin
                    if (slot_val[i] > r.mx) r.mx = slot_val[i];
                    if (slot_val[i] < r.mn) r.mn = slot_val[i];
                end
            end
        return r;
    endfunction

    // Sender: random gap, then one beat. Valid stays up into the next call when
    // the next gap is zero; drain() drops it.
    task automatic send_req(req_row_t row);
        answer_t exp_ans;
        int unsigned gap;
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type    <= row.kind;
        left_index  <= row.lidx;
        right_index <= row.ridx;
        new_value   <= row.val;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        exp_ans = predict_answer(row.kind, row.lidx, row.ridx, row.val);
        if (row.typed && (exp_ans.mx !== row.emax || exp_ans.mn !== row.emin
                          || exp_ans.any !== row.eany || exp_ans.st !== row.est))
        begin
            $error("table row disagrees with predictor");
            errors++;
        end
        pending_answers.insert(pending_answers.size(), exp_ans);
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_answers.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (60) @(negedge clk);
    endtask

    task automatic write_slot_count(logic [IDX_W-1:0] n);
        drain();
        cfg_data  <= n;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        slots_live = n;
        clear_slots();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: waits a random gap before each beat, longer while hold_off is set.
    initial
    begin
        int unsigned rx_gap;
        forever
        begin
            rx_gap = $urandom_range(0, 4);
            if (rx_gap != 0 || hold_off)
            begin
                out_ready <= 1'b0;
                repeat (rx_gap) @(negedge clk);
                while (hold_off) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                answer_t e;
                e = pending_answers.pop_front();
                if (range_max !== e.mx)
                begin
                    $error("range_max expected %0d got %0d", e.mx, range_max);
                    errors++;
                end
                if (range_min !== e.mn)
                begin
                    $error("range_min expected %0d got %0d", e.mn, range_min);
                    errors++;
                end
                if (any_set !== e.any)
                begin
                    $error("any_set expected %0d got %0d", e.any, any_set);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $error("status expected %0d got %0d", e.st, status);
                    errors++;
                end
            end
        end

    function automatic req_row_t rand_row(int unsigned n);
        req_row_t r;
        int unsigned lo, hi, t;
        r = '{default: '0};
        r.kind = 1'($urandom_range(0, 1));
        lo = $urandom_range(1, n);
        hi = $urandom_range(1, n);
        if (r.kind == OP_QUERY && lo > hi)
        begin
            t = lo;
            lo = hi;
            hi = t;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            // noise: any index pattern at all, including 0 and above range
            lo = $urandom_range(0, 2047);
            hi = $urandom_range(0, 2047);
        end
        r.lidx = IDX_W'(lo);
        r.ridx = IDX_W'(hi);
        case ($urandom_range(0, 5))
            0: r.val = 32'sh7fffffff;
            1: r.val = 32'sh80000000;
            default: r.val = $urandom();
        endcase
        return r;
    endfunction

    req_row_t directed [$];

    initial
    begin
        int unsigned sizes [6];
        sizes = '{1024, 1, 2047, 0, 7, 300};
        clear_slots();
        directed = '{
            '{OP_QUERY, 1, 1024, 0, 1, 0, 0, 0, STAT_OK},
            '{OP_UPDATE, 1, 0, 32'sh7fffffff, 1, 0, 0, 0, STAT_OK},
            '{OP_UPDATE, 1024, 0, 32'sh80000000, 1, 0, 0, 0, STAT_OK},
            '{OP_QUERY, 1, 1024, 0, 1, 32'sh7fffffff, 32'sh80000000, 1, STAT_OK},
            '{OP_QUERY, 2, 1023, 0, 1, 0, 0, 0, STAT_OK},
            '{OP_UPDATE, 0, 0, 5, 1, 0, 0, 0, STAT_BADIDX},
            '{OP_UPDATE, 1025, 0, 5, 1, 0, 0, 0, STAT_BADIDX},
            '{OP_UPDATE, 2047, 2047, -1, 1, 0, 0, 0, STAT_BADIDX},
            '{OP_QUERY, 0, 5, 0, 1, 0, 0, 0, STAT_BADIDX},
            '{OP_QUERY, 5, 1025, 0, 1, 0, 0, 0, STAT_BADIDX},
            '{OP_QUERY, 9, 8, 0, 1, 0, 0, 0, STAT_BADIDX},
            '{OP_UPDATE, 500, 0, -7, 0, 0, 0, 0, STAT_OK},
            '{OP_UPDATE, 500, 0, 42, 0, 0, 0, 0, STAT_OK},
            '{OP_QUERY, 500, 500, 0, 1, 42, 42, 1, STAT_OK},
            '{OP_QUERY, 1024, 1024, 0, 1, 32'sh80000000, 32'sh80000000, 1, STAT_OK},
            '{OP_QUERY, 2, 999, 0, 0, 0, 0, 0, STAT_OK}
        };
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        foreach (directed[i])
            send_req(directed[i]);
        // fill-up: receiver held off while requests keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 6; k++)
                send_req(rand_row(1024));
        join
        for (int ph = 0; ph < 6; ph++)
        begin
            int unsigned n;
            write_slot_count(IDX_W'(sizes[ph]));
            n = (slots_live == 0) ? 1 : ((slots_live > LEAVES) ? LEAVES : slots_live);
            for (int k = 0; k < 90; k++)
                send_req(rand_row(n));
        end
        drain();
        if (pending_answers.size() != 0)
            errors++;
        if (errors == 0)
            $display("range_min_max_segment_tree test passed");
        else
            $display("range_min_max_segment_tree test failed");
        $finish;
    end
endmodule
